@@ sv/bwf_pkg.sv @@
package bwf_pkg;

    // Default sizing
    localparam int DEF_NUM_SLOTS = 8;
    localparam int DEF_SIZE_BITS = 16;

    // Fixed field widths
    localparam int SLOT_FIELD_W = 3;
    localparam int AMT_W        = 16;
    localparam int TAG_W        = 8;

    // Request kinds
    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_ALLOC = 1'b1;

    // Fit policies
    localparam logic POL_BEST  = 1'b0;
    localparam logic POL_WORST = 1'b1;

    // Controller to datapath
    typedef struct packed {
        logic load;     // load item accepted this cycle
        logic start;    // allocate item accepted this cycle
        logic read;     // read slot at scan counter
        logic commit;   // charge chosen slot, load result register
    } bwf_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic scan_last;  // scan counter at final slot
        logic out_busy;   // result register full and stalled
    } bwf_status_t;

endpackage

@@ sv/bwf_ram.sv @@
module bwf_ram
#(
    parameter int WIDTH = 16,
    parameter int DEPTH = 8,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
)
(
    input  logic                 clk,
    input  logic                 wr_en,
    input  logic [ADDR_W-1:0]    wr_addr,
    input  logic [WIDTH-1:0]     wr_data,
    input  logic                 rd_en,
    input  logic [ADDR_W-1:0]    rd_addr,
    output logic [WIDTH-1:0]     rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ sv/bwf_datapath.sv @@
module bwf_datapath
    import bwf_pkg::*;
#(
    parameter int NUM_SLOTS = DEF_NUM_SLOTS,
    parameter int SIZE_BITS = DEF_SIZE_BITS
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  bwf_cmd_t                 cmd,
    output bwf_status_t              status,
    input  logic                     cfg_valid,
    input  logic                     cfg_ready,
    input  logic                     cfg_data,
    input  logic [SLOT_FIELD_W-1:0]  slot_select,
    input  logic [AMT_W-1:0]         amount,
    input  logic [TAG_W-1:0]         request_tag,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic                     granted,
    output logic [SLOT_FIELD_W-1:0]  granted_slot,
    output logic [AMT_W-1:0]         remaining_capacity,
    output logic [TAG_W-1:0]         result_tag
);

    localparam int IDX_W   = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int SEL_X_W = IDX_W + SLOT_FIELD_W;
    localparam int CMP_W   = SIZE_BITS + AMT_W;

    // control state
    logic                  policy_reg;
    logic [NUM_SLOTS-1:0]  valid_reg;
    logic                  rd_pend_reg;
    logic                  found_reg;
    logic                  out_valid_reg;

    // payload state
    logic [AMT_W-1:0]      amt_reg;
    logic [TAG_W-1:0]      tag_reg;
    logic [IDX_W-1:0]      scan_cnt_reg;
    logic [IDX_W-1:0]      rd_idx_reg;
    logic                  rd_vld_reg;
    logic [IDX_W-1:0]      pick_reg;
    logic [SIZE_BITS-1:0]  pick_cap_reg;
    logic                  granted_reg;
    logic [SLOT_FIELD_W-1:0] granted_slot_reg;
    logic [AMT_W-1:0]      remaining_reg;
    logic [TAG_W-1:0]      result_tag_reg;

    logic [SEL_X_W-1:0]    sel_ext;
    logic                  sel_in_range;
    logic [CMP_W-1:0]      amount_ext;
    logic [SIZE_BITS-1:0]  load_cap;
    logic [CMP_W-1:0]      amt_reg_ext;
    logic [SIZE_BITS-1:0]  rd_cap;
    logic [CMP_W-1:0]      rd_cap_ext;
    logic                  fits;
    logic                  take;
    logic [CMP_W-1:0]      left_ext;
    logic [SIZE_BITS-1:0]  left;
    logic [CMP_W-1:0]      left_wide;
    logic [SEL_X_W-1:0]    pick_ext;
    logic                  wr_en;
    logic [IDX_W-1:0]      wr_addr;
    logic [SIZE_BITS-1:0]  wr_data;
    logic [SIZE_BITS-1:0]  ram_rdata;

    // load decode
    assign sel_ext      = {{IDX_W{1'b0}}, slot_select};
    assign sel_in_range = sel_ext < SEL_X_W'(NUM_SLOTS);
    assign amount_ext   = {{SIZE_BITS{1'b0}}, amount};
    assign load_cap     = amount_ext[SIZE_BITS-1:0];

    // compare stage; never-written slots read as empty
    assign rd_cap      = rd_vld_reg ? ram_rdata : '0;
    assign rd_cap_ext  = {{AMT_W{1'b0}}, rd_cap};
    assign amt_reg_ext = {{SIZE_BITS{1'b0}}, amt_reg};
    assign fits        = rd_cap_ext >= amt_reg_ext;
    assign take        = rd_pend_reg && fits &&
                         (!found_reg ||
                          (policy_reg == POL_BEST  && rd_cap < pick_cap_reg) ||
                          (policy_reg == POL_WORST && rd_cap > pick_cap_reg));

    // charge; pick_cap >= amt so no wrap
    assign left_ext  = {{AMT_W{1'b0}}, pick_cap_reg} - amt_reg_ext;
    assign left      = left_ext[SIZE_BITS-1:0];
    assign left_wide = {{AMT_W{1'b0}}, left};
    assign pick_ext  = {{SLOT_FIELD_W{1'b0}}, pick_reg};

    // single write port: loads in idle, charge at commit
    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = sel_ext[IDX_W-1:0];
        wr_data = load_cap;
        if (cmd.commit)
        begin
            wr_en   = found_reg;
            wr_addr = pick_reg;
            wr_data = left;
        end
        else if (cmd.load)
        begin
            wr_en = sel_in_range;
        end
    end

    bwf_ram #(
        .WIDTH (SIZE_BITS),
        .DEPTH (NUM_SLOTS)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (cmd.read),
        .rd_addr (scan_cnt_reg),
        .rd_data (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            policy_reg    <= POL_BEST;
            valid_reg     <= '0;
            rd_pend_reg   <= 1'b0;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                policy_reg <= cfg_data;
            end
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            rd_pend_reg <= cmd.read;
            if (cmd.start)
            begin
                found_reg <= 1'b0;
            end
            else if (take)
            begin
                found_reg <= 1'b1;
            end
            if (cmd.commit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            amt_reg      <= amount;
            tag_reg      <= request_tag;
            scan_cnt_reg <= '0;
        end
        else if (cmd.read)
        begin
            scan_cnt_reg <= scan_cnt_reg + IDX_W'(1);
        end
        if (cmd.read)
        begin
            rd_idx_reg <= scan_cnt_reg;
            rd_vld_reg <= valid_reg[scan_cnt_reg];
        end
        if (take)
        begin
            pick_reg     <= rd_idx_reg;
            pick_cap_reg <= rd_cap;
        end
        if (cmd.commit)
        begin
            granted_reg      <= found_reg;
            granted_slot_reg <= found_reg ? pick_ext[SLOT_FIELD_W-1:0] : '0;
            remaining_reg    <= found_reg ? left_wide[AMT_W-1:0] : '0;
            result_tag_reg   <= tag_reg;
        end
    end

    assign status.scan_last = scan_cnt_reg == IDX_W'(NUM_SLOTS - 1);
    assign status.out_busy  = out_valid_reg && out_stall;

    assign out_valid          = out_valid_reg;
    assign granted            = granted_reg;
    assign granted_slot       = granted_slot_reg;
    assign remaining_capacity = remaining_reg;
    assign result_tag         = result_tag_reg;

endmodule

@@ sv/bwf_ctrl.sv @@
module bwf_ctrl
    import bwf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        req_type,
    input  bwf_status_t status,
    output bwf_cmd_t    cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_COMMIT
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    assign in_stall = state_reg != ST_IDLE;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                cmd.load  = accept && req_type == REQ_LOAD;
                cmd.start = accept && req_type == REQ_ALLOC;
                if (cmd.start)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                cmd.read = 1'b1;
                if (status.scan_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_COMMIT;
            end
            ST_COMMIT:
            begin
                if (!status.out_busy)
                begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

@@ sv/best_worst_fit_allocator.sv @@
// Load item: accepted with no result; next item may follow at once.
// Allocate item: a scan over the slot RAM, one read per cycle, then compare
// and charge steps; the charge waits while a stalled result still holds the
// result register. Next item is accepted the cycle after the result is loaded,
// so an allocate is finished before the next item is taken.
// Reset (rst_n, async, active low): all slots empty, best-fit policy, idle.
module best_worst_fit_allocator
    import bwf_pkg::*;
#(
    parameter int NUM_SLOTS = DEF_NUM_SLOTS,
    parameter int SIZE_BITS = DEF_SIZE_BITS
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    // configuration: fit_policy
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic                     cfg_data,
    // request items
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic                     req_type,
    input  logic [SLOT_FIELD_W-1:0]  slot_select,
    input  logic [AMT_W-1:0]         amount,
    input  logic [TAG_W-1:0]         request_tag,
    // result items
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic                     granted,
    output logic [SLOT_FIELD_W-1:0]  granted_slot,
    output logic [AMT_W-1:0]         remaining_capacity,
    output logic [TAG_W-1:0]         result_tag
);

    bwf_cmd_t    cmd;
    bwf_status_t status;

    // Policy register takes a write any cycle; the user must write it only while idle, the block does not enforce this.
    assign cfg_ready = 1'b1;

    // Controller: accepts items, steps the slot scan, and holds the commit
    // until the result register is free. A waiting result does not block
    // the scan of the next request.
    bwf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .req_type (req_type),
        .status   (status),
        .cmd      (cmd)
    );

    // Datapath: slot capacity RAM with per-slot valid bits (an unwritten
    // slot reads as empty), running best/worst pick over the scan, charge
    // write-back, policy register and the result register.
    bwf_datapath #(
        .NUM_SLOTS (NUM_SLOTS),
        .SIZE_BITS (SIZE_BITS)
    ) u_dp (
        .clk                (clk),
        .rst_n              (rst_n),
        .cmd                (cmd),
        .status             (status),
        .cfg_valid          (cfg_valid),
        .cfg_ready          (cfg_ready),
        .cfg_data           (cfg_data),
        .slot_select        (slot_select),
        .amount             (amount),
        .request_tag        (request_tag),
        .out_valid          (out_valid),
        .out_stall          (out_stall),
        .granted            (granted),
        .granted_slot       (granted_slot),
        .remaining_capacity (remaining_capacity),
        .result_tag         (result_tag)
    );

endmodule

@@ sv/bwf_checker.sv @@
module bwf_checker
    import bwf_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_valid,
    input  logic                     cfg_ready,
    input  logic                     cfg_data,
    input  logic                     in_valid,
    input  logic                     in_stall,
    input  logic                     req_type,
    input  logic [SLOT_FIELD_W-1:0]  slot_select,
    input  logic [AMT_W-1:0]         amount,
    input  logic [TAG_W-1:0]         request_tag,
    input  logic                     out_valid,
    input  logic                     out_stall,
    input  logic                     granted,
    input  logic [SLOT_FIELD_W-1:0]  granted_slot,
    input  logic [AMT_W-1:0]         remaining_capacity,
    input  logic [TAG_W-1:0]         result_tag
);

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(granted) &&
        $stable(granted_slot) && $stable(remaining_capacity) && $stable(result_tag))
        else $error("stalled result changed");

    // a refused request reports slot and capacity as zero
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !granted |-> granted_slot == '0 && remaining_capacity == '0)
        else $error("failed result carries slot or capacity");

    // an accepted allocation keeps the input side busy for the scan
    a_alloc_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && req_type == REQ_ALLOC |=> in_stall)
        else $error("input not stalled after allocate item");

    // a new result only comes out of a running allocation
    a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result without allocation in progress");

endmodule

bind best_worst_fit_allocator bwf_checker u_bwf_checker (.*);

@@ verif/tb_best_worst_fit_allocator.sv @@
module tb_best_worst_fit_allocator;
    import bwf_pkg::*;

    // Sizing follows the block defaults; the instance uses no overrides.
    localparam int SLOTS            = DEF_NUM_SLOTS;
    localparam int CAP_W            = DEF_SIZE_BITS;
    // Pause longer than one allocate takes before touching the policy register,
    // in case a load is still in flight.
    localparam int DRAIN_CYCLES     = DEF_NUM_SLOTS + 12;
    localparam int QUIET_LIMIT      = 3000;
    localparam int HOLD_CYCLES      = 400;
    localparam int RANDOM_PER_PHASE = 150;
    localparam int MAX_GAP          = 12;

    typedef struct packed {
        logic                    kind;
        logic [SLOT_FIELD_W-1:0] slot;
        logic [AMT_W-1:0]        amt;
        logic [TAG_W-1:0]        tag;
    } request_t;

    typedef struct packed {
        logic                    granted;
        logic [SLOT_FIELD_W-1:0] slot;
        logic [AMT_W-1:0]        left;
        logic [TAG_W-1:0]        tag;
    } grant_t;

    // Typed-in answer for a directed allocate; fixed = 0 means use the predictor.
    typedef struct packed {
        logic   fixed;
        grant_t g;
    } hand_answer_t;

    typedef enum logic [1:0] {ROW_LOAD, ROW_ALLOC, ROW_POLICY} row_kind_e;

    typedef struct {
        row_kind_e               kind;
        logic [SLOT_FIELD_W-1:0] slot;
        logic [AMT_W-1:0]        amt;
        logic [TAG_W-1:0]        tag;
        logic                    pol;
        logic                    fixed;
        logic                    ok;
        logic [SLOT_FIELD_W-1:0] gslot;
        logic [AMT_W-1:0]        left;
    } row_t;

    logic                    clk;
    logic                    rst_n;
    logic                    cfg_valid;
    logic                    cfg_ready;
    logic                    cfg_data;
    logic                    in_valid;
    logic                    in_stall;
    logic                    req_type;
    logic [SLOT_FIELD_W-1:0] slot_select;
    logic [AMT_W-1:0]        amount;
    logic [TAG_W-1:0]        request_tag;
    logic                    out_valid;
    logic                    out_stall;
    logic                    granted;
    logic [SLOT_FIELD_W-1:0] granted_slot;
    logic [AMT_W-1:0]        remaining_capacity;
    logic [TAG_W-1:0]        result_tag;

    // Shadow of the block: free capacity per slot and the fit policy.
    logic [CAP_W-1:0] slot_free [SLOTS];
    logic             policy_now;

    grant_t       expected_grants [$];
    hand_answer_t hand_checked [$];
    row_t         directed_rows [$];

    int   mismatch_count = 0;
    int   send_idle_pct  = 0;
    int   recv_idle_pct  = 0;
    logic hold_req       = 1'b0;

    best_worst_fit_allocator uut (
        .clk                (clk),
        .rst_n              (rst_n),
        .cfg_valid          (cfg_valid),
        .cfg_ready          (cfg_ready),
        .cfg_data           (cfg_data),
        .in_valid           (in_valid),
        .in_stall           (in_stall),
        .req_type           (req_type),
        .slot_select        (slot_select),
        .amount             (amount),
        .request_tag        (request_tag),
        .out_valid          (out_valid),
        .out_stall          (out_stall),
        .granted            (granted),
        .granted_slot       (granted_slot),
        .remaining_capacity (remaining_capacity),
        .result_tag         (result_tag)
    );

    initial clk = 1'b0;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Allocate: scan every slot that can hold the request, best fit keeps the
    // smallest such capacity, worst fit the largest, strict compare so the
    // lowest index wins a tie. Charge the winner and report what is left.
    function automatic grant_t charge_fitting_slot(input logic [AMT_W-1:0] want,
                                                   input logic [TAG_W-1:0] tag);
        grant_t           res;
        logic             hit;
        int               pick;
        int               k;
        logic [CAP_W-1:0] pick_cap;
        hit      = 1'b0;
        pick     = 0;
        pick_cap = '0;
        for (k = 0; k < SLOTS; k++)
        begin
            if (slot_free[k] >= want)
            begin
                if (!hit ||
                    (policy_now == POL_BEST  && slot_free[k] < pick_cap) ||
                    (policy_now == POL_WORST && slot_free[k] > pick_cap))
                begin
                    hit      = 1'b1;
                    pick     = k;
                    pick_cap = slot_free[k];
                end
            end
        end
        res.granted = hit;
        res.tag     = tag;
        if (hit)
        begin
            slot_free[pick] = pick_cap - want;
            res.slot        = pick[SLOT_FIELD_W-1:0];
            res.left        = slot_free[pick];
        end
        else
        begin
            res.slot = '0;
            res.left = '0;
        end
        return res;
    endfunction

    // Random item mix: allocates dominate; sizes lean small so that slots
    // are hit often, with zero, full-scale and wide values mixed in.
    function automatic request_t random_request(input logic allocs_only);
        request_t r;
        int       pick;
        r.kind = (allocs_only || $urandom_range(99) < 60) ? REQ_ALLOC : REQ_LOAD;
        r.slot = SLOT_FIELD_W'($urandom);
        r.tag  = TAG_W'($urandom);
        pick   = $urandom_range(99);
        if (r.kind == REQ_LOAD)
        begin
            if (pick < 7)
                r.amt = '0;
            else if (pick < 15)
                r.amt = '1;
            else if (pick < 40)
                r.amt = AMT_W'($urandom_range(300));
            else
                r.amt = AMT_W'($urandom);
        end
        else
        begin
            if (pick < 10)
                r.amt = '0;
            else if (pick < 20)
                r.amt = '1;
            else if (pick < 55)
                r.amt = AMT_W'($urandom_range(300));
            else if (pick < 70)
                r.amt = AMT_W'($urandom_range(4095));
            else
                r.amt = AMT_W'($urandom);
        end
        return r;
    endfunction

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    // Present one item, with a random gap before it, and hold it until taken.
    // in_valid stays high on return so back-to-back items need no extra edge.
    task automatic send_item(input request_t r, input logic fixed, input grant_t g);
        int gap;
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(99) < send_idle_pct)
            gap++;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        hand_checked.push_back('{fixed, g});
        in_valid    <= 1'b1;
        req_type    <= r.kind;
        slot_select <= r.slot;
        amount      <= r.amt;
        request_tag <= r.tag;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    task automatic send_random(input int count, input logic allocs_only);
        int i;
        for (i = 0; i < count; i++)
            send_item(random_request(allocs_only), 1'b0, '0);
    endtask

    // Stop offering, wait for every pending grant, then let a trailing load
    // finish before the block counts as idle.
    task automatic drain_block();
        in_valid <= 1'b0;
        while (expected_grants.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_policy(input logic pol);
        drain_block();
        cfg_valid <= 1'b1;
        cfg_data  <= pol;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // Checker: all handshakes are sampled at the rising edge, before the
    // block's own updates land, so both sides see the same cycle.
    always @(posedge clk)
    begin : scoreboard
        hand_answer_t ha;
        grant_t       want;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                policy_now = cfg_data;

            if (out_valid && !out_stall)
            begin
                if (expected_grants.size() == 0)
                begin
                    $display("%0t: unexpected result: expected none, actual slot %0d tag %0d",
                             $time, granted_slot, result_tag);
                    mismatch_count++;
                end
                else
                begin
                    want = expected_grants.pop_front();
                    compare_field("granted", 32'(want.granted), 32'(granted));
                    compare_field("granted_slot", 32'(want.slot), 32'(granted_slot));
                    compare_field("remaining_capacity", 32'(want.left),
                                  32'(remaining_capacity));
                    compare_field("result_tag", 32'(want.tag), 32'(result_tag));
                end
            end

            if (in_valid && !in_stall)
            begin
                ha = (hand_checked.size() != 0) ? hand_checked.pop_front() : '0;
                if (req_type == REQ_LOAD)
                begin
                    // load: no result; slot_select always in range at 8 slots
                    if (slot_select < SLOTS)
                        slot_free[slot_select] = amount;
                end
                else
                begin
                    // shadow state moves even when the answer was typed in
                    want = charge_fitting_slot(amount, request_tag);
                    expected_grants.push_back(ha.fixed ? ha.g : want);
                end
            end
        end
    end

    // Result side: random stalls per phase, plus one long hold-off to fill
    // the block and push back on the request side.
    initial
    begin : receiver
        int hold_left;
        hold_left = 0;
        out_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else
                out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // Watchdog: any handshake counts as progress.
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
                (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("FAIL best_worst_fit_allocator");
        $finish;
    end

    initial
    begin : stimulus
        int i;
        rst_n       = 1'b0;
        cfg_valid   = 1'b0;
        cfg_data    = POL_BEST;
        in_valid    = 1'b0;
        req_type    = REQ_LOAD;
        slot_select = '0;
        amount      = '0;
        request_tag = '0;
        policy_now  = POL_BEST;
        for (i = 0; i < SLOTS; i++)
            slot_free[i] = '0;

        // Directed rows. Typed answers only where obvious: empty slots after
        // reset, full-scale requests, and requests nothing can hold.
        // All slots empty, best fit: zero request fits slot 0 and leaves it.
        directed_rows.push_back('{ROW_ALLOC, 3'd3, 16'h0000, 8'h00, POL_BEST,
                                  1'b1, 1'b1, 3'd0, 16'h0000});
        // Nothing fits a nonzero request.
        directed_rows.push_back('{ROW_ALLOC, 3'd7, 16'hFFFF, 8'hFF, POL_BEST,
                                  1'b1, 1'b0, 3'd0, 16'h0000});
        directed_rows.push_back('{ROW_ALLOC, 3'd0, 16'h0001, 8'hA5, POL_BEST,
                                  1'b1, 1'b0, 3'd0, 16'h0000});
        // One full slot, full-scale request drains it exactly.
        directed_rows.push_back('{ROW_LOAD, 3'd7, 16'hFFFF, 8'h00, POL_BEST,
                                  1'b0, 1'b0, 3'd0, 16'h0000});
        directed_rows.push_back('{ROW_ALLOC, 3'd5, 16'hFFFF, 8'h5A, POL_BEST,
                                  1'b1, 1'b1, 3'd7, 16'h0000});
        // Fill all slots; slots 3 and 5 tie, slots 5 and 6 end up empty.
        directed_rows.push_back('{ROW_LOAD, 3'd0, 16'd100, 8'h11, POL_BEST,
                                  1'b0, 1'b0, 3'd0, 16'h0000});
        directed_rows.push_back('{ROW_LOAD, 3'd1, 16'h8000, 8'h22, POL_BEST,
                                  1'b0, 1'b0, 3'd0, 16'h0000});
        directed_rows.push_back('{ROW_LOAD, 3'd2, 16'h0001, 8'h33, POL_BEST,
                                  1'b0, 1'b0, 3'd0, 16'h0000});
        directed_rows.push_back('{ROW_LOAD, 3'd3, 16'd50, 8'h44, POL_BEST,
                                  1'b0, 1'b0, 3'd0, 16'h0000});
        directed_rows.push_back('{ROW_LOAD, 3'd4, 16'hFFFF, 8'h55, POL_BEST,
                                  1'b0, 1'b0, 3'd0, 16'h0000});
        directed_rows.push_back('{ROW_LOAD, 3'd5, 16'd50, 8'h66, POL_BEST,
                                  1'b0, 1'b0, 3'd0, 16'h0000});
        directed_rows.push_back('{ROW_LOAD, 3'd6, 16'h0000, 8'h77, POL_BEST,
                                  1'b0, 1'b0, 3'd0, 16'h0000});
        directed_rows.push_back('{ROW_LOAD, 3'd7, 16'hFFFE, 8'h88, POL_BEST,
                                  1'b0, 1'b0, 3'd0, 16'h0000});
        // Best fit: tie goes low, exact fit, zero request picks an empty slot.
        directed_rows.push_back('{ROW_ALLOC, 3'd6, 16'd40, 8'h01, POL_BEST,
                                  1'b0, 1'b0, 3'd0, 16'h0000});
        directed_rows.push_back('{ROW_ALLOC, 3'd1, 16'd50, 8'h02, POL_BEST,
                                  1'b0, 1'b0, 3'd0, 16'h0000});
        directed_rows.push_back('{ROW_ALLOC, 3'd2, 16'h0000, 8'h03, POL_BEST,
                                  1'b0, 1'b0, 3'd0, 16'h0000});
        directed_rows.push_back('{ROW_ALLOC, 3'd4, 16'hFFFF, 8'h04, POL_BEST,
                                  1'b1, 1'b1, 3'd4, 16'h0000});
        // Worst fit: largest slot, full-scale request that no slot holds.
        directed_rows.push_back('{ROW_POLICY, 3'd0, 16'h0000, 8'h00, POL_WORST,
                                  1'b0, 1'b0, 3'd0, 16'h0000});
        directed_rows.push_back('{ROW_ALLOC, 3'd0, 16'h0001, 8'h05, POL_WORST,
                                  1'b0, 1'b0, 3'd0, 16'h0000});
        directed_rows.push_back('{ROW_ALLOC, 3'd7, 16'h8000, 8'h06, POL_WORST,
                                  1'b0, 1'b0, 3'd0, 16'h0000});
        directed_rows.push_back('{ROW_ALLOC, 3'd3, 16'hFFFF, 8'h07, POL_WORST,
                                  1'b1, 1'b0, 3'd0, 16'h0000});
        directed_rows.push_back('{ROW_ALLOC, 3'd5, 16'h0000, 8'h08, POL_WORST,
                                  1'b0, 1'b0, 3'd0, 16'h0000});
        // Two full slots tie under worst fit.
        directed_rows.push_back('{ROW_LOAD, 3'd0, 16'hFFFF, 8'h99, POL_WORST,
                                  1'b0, 1'b0, 3'd0, 16'h0000});
        directed_rows.push_back('{ROW_LOAD, 3'd2, 16'hFFFF, 8'hAA, POL_WORST,
                                  1'b0, 1'b0, 3'd0, 16'h0000});
        directed_rows.push_back('{ROW_ALLOC, 3'd2, 16'd16, 8'h09, POL_WORST,
                                  1'b0, 1'b0, 3'd0, 16'h0000});
        directed_rows.push_back('{ROW_ALLOC, 3'd6, 16'hFFFF, 8'h0A, POL_WORST,
                                  1'b0, 1'b0, 3'd0, 16'h0000});
        directed_rows.push_back('{ROW_POLICY, 3'd0, 16'h0000, 8'h00, POL_BEST,
                                  1'b0, 1'b0, 3'd0, 16'h0000});
        directed_rows.push_back('{ROW_ALLOC, 3'd1, 16'h0002, 8'hC3, POL_BEST,
                                  1'b0, 1'b0, 3'd0, 16'h0000});

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Phase 1: sender idles lightly, receiver stalls heavily.
        send_idle_pct = 19;
        recv_idle_pct = 46;
        foreach (directed_rows[i])
        begin
            case (directed_rows[i].kind)
                ROW_POLICY:
                    set_policy(directed_rows[i].pol);
                ROW_LOAD:
                    send_item('{REQ_LOAD, directed_rows[i].slot, directed_rows[i].amt,
                                directed_rows[i].tag}, 1'b0, '0);
                default:
                    send_item('{REQ_ALLOC, directed_rows[i].slot, directed_rows[i].amt,
                                directed_rows[i].tag}, directed_rows[i].fixed,
                              '{directed_rows[i].ok, directed_rows[i].gslot,
                                directed_rows[i].left, directed_rows[i].tag});
            endcase
        end
        set_policy(POL_WORST);
        send_random(RANDOM_PER_PHASE, 1'b0);

        // Phase 2: roles swapped.
        set_policy(POL_BEST);
        send_idle_pct = 46;
        recv_idle_pct = 19;
        send_random(RANDOM_PER_PHASE, 1'b0);

        // Phase 3: no idling; open with a long receiver hold-off while the
        // sender keeps offering allocates so the block backs up.
        set_policy(POL_WORST);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_req      = 1'b1;
        send_random(40, 1'b1);
        send_random(RANDOM_PER_PHASE - 40, 1'b0);

        drain_block();
        if (mismatch_count == 0 && expected_grants.size() == 0)
            $display("PASS best_worst_fit_allocator");
        else
            $display("FAIL best_worst_fit_allocator");
        $finish;
    end

endmodule

@@ filelist.f @@
sv/bwf_pkg.sv
sv/bwf_ram.sv
sv/bwf_datapath.sv
sv/bwf_ctrl.sv
sv/best_worst_fit_allocator.sv
sv/bwf_checker.sv
verif/tb_best_worst_fit_allocator.sv
